FILE: hw/rtl/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// Shared codes, constants and controller/datapath interface types for the
// projectile slot physics block.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_SPAWN = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CULL  = 2'd2
  } cmd_t;

  // Report kinds
  typedef enum logic [1:0] {
    KIND_SPAWN = 2'd0,
    KIND_POS   = 2'd1,
    KIND_CULL  = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAUNCH_SPEED  = 3'd0,
    REG_GRAVITY       = 3'd1,
    REG_MUZZLE_OFFSET = 3'd2,
    REG_FIELD_WIDTH   = 3'd3,
    REG_FIELD_HEIGHT  = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [9:0]  RST_LAUNCH_SPEED  = 10'd450;
  localparam logic [9:0]  RST_GRAVITY       = 10'd150;
  localparam logic [7:0]  RST_MUZZLE_OFFSET = 8'd35;
  localparam logic [11:0] RST_FIELD_WIDTH   = 12'd640;
  localparam logic [11:0] RST_FIELD_HEIGHT  = 12'd480;

  // CORDIC in Q16, angle input carries 13 fraction bits
  localparam int                 TRIG_STEPS  = 16;
  localparam int                 SQRT_STEPS  = 11;
  localparam logic signed [20:0] CORDIC_GAIN = 21'sd39797;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;

  // floor(w/125) = (w * DIV_MUL) >> DIV_SHIFT for w below 2^31
  localparam logic [31:0] DIV_MUL   = 32'd2199023256;
  localparam int          DIV_SHIFT = 38;

  function automatic logic signed [20:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0:    return 21'sd51472;
      4'd1:    return 21'sd30385;
      4'd2:    return 21'sd16055;
      4'd3:    return 21'sd8150;
      4'd4:    return 21'sd4091;
      4'd5:    return 21'sd2047;
      4'd6:    return 21'sd1024;
      4'd7:    return 21'sd512;
      4'd8:    return 21'sd256;
      4'd9:    return 21'sd128;
      4'd10:   return 21'sd64;
      4'd11:   return 21'sd32;
      4'd12:   return 21'sd16;
      4'd13:   return 21'sd8;
      4'd14:   return 21'sd4;
      default: return 21'sd2;
    endcase
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic trig_go;
    logic dv_sel;
    logic dv_cap;
    logic sp_commit;
    logic emit_full;
    logic tk_commit;
    logic cl_check;
    logic cl_emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic idx_end;
    logic live_here;
    logic trig_busy;
    logic out_free;
    logic rep_room;
  } dp_stat_t;

endpackage

FILE: hw/rtl/psp_div1000.sv
// ----------------------------------------------------------------------------
// psp_div1000
// Two-stage pipelined rounded division by 1000: floor((num + 500) / 1000).
// ----------------------------------------------------------------------------
module psp_div1000 (
  input  logic               clk,
  input  logic signed [35:0] num,
  output logic signed [25:0] quo
);
  import psp_pkg::*;

  logic signed [35:0] t;
  logic               neg;
  logic [35:0]        u;
  logic [30:0]        s1_w;
  logic               s1_neg;
  logic [62:0]        s2_p;
  logic               s2_neg;
  logic [24:0]        q;

  // Fold negative values onto a ceiling of the magnitude, then drop by 8
  always_comb begin
    t   = num + 36'sd500;
    neg = t[35];
    if (neg) begin
      u = 36'(-t + 36'sd999);
    end else begin
      u = 36'(t);
    end
  end

  always_ff @(posedge clk) begin
    s1_w   <= u[33:3];
    s1_neg <= neg;
    s2_p   <= s1_w * DIV_MUL;
    s2_neg <= s1_neg;
  end

  // Divide by 125 through the reciprocal, restore the sign
  assign q   = 25'(s2_p >> DIV_SHIFT);
  assign quo = s2_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

FILE: hw/rtl/psp_trig.sv
// ----------------------------------------------------------------------------
// psp_trig
// Iterative unit: 16-step CORDIC for cos and sin, and an 11-step integer
// square root of the launch power times 256, both one step per cycle.
// ----------------------------------------------------------------------------
module psp_trig (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] angle,
  input  logic [11:0]        power,
  output logic               busy,
  output logic signed [20:0] cos_v,
  output logic signed [20:0] sin_v,
  output logic [9:0]         root
);
  import psp_pkg::*;

  logic signed [20:0] x, y, z;
  logic               flip;
  logic [3:0]         step;
  logic [19:0]        rn;
  logic [20:0]        rr;
  logic signed [20:0] za;
  logic signed [20:0] dx, dy;
  logic [20:0]        bitv;
  logic [20:0]        sum;

  assign za   = {{2{angle[15]}}, angle, 3'b000};
  assign dx   = y >>> step;
  assign dy   = x >>> step;
  assign bitv = 21'd1 << (5'd20 - 5'({step, 1'b0}));
  assign sum  = rr + bitv;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 4'd1;
      if (step == 4'(TRIG_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Rotate and square-root iterations
  always_ff @(posedge clk) begin
    if (start) begin
      x  <= CORDIC_GAIN;
      y  <= '0;
      rn <= {power, 8'h00};
      rr <= '0;
      if (za > HALF_PI_Q16) begin
        z    <= za - PI_Q16;
        flip <= 1'b1;
      end else if (za < -HALF_PI_Q16) begin
        z    <= za + PI_Q16;
        flip <= 1'b1;
      end else begin
        z    <= za;
        flip <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_q16(step);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_q16(step);
      end
      if (step < 4'(SQRT_STEPS)) begin
        if ({1'b0, rn} >= sum) begin
          rn <= rn - sum[19:0];
          rr <= (rr >> 1) + bitv;
        end else begin
          rr <= rr >> 1;
        end
      end
    end
  end

  assign cos_v = flip ? -x : x;
  assign sin_v = flip ? -y : y;
  assign root  = rr[9:0];

endmodule

FILE: hw/rtl/psp_datapath.sv
// ----------------------------------------------------------------------------
// psp_datapath
// Slot store, configuration registers, spawn and tick arithmetic, cull
// checks and the result register.
// ----------------------------------------------------------------------------
module psp_datapath #(
  parameter int SLOTS     = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  psp_pkg::dp_cmd_t                cmd,
  output psp_pkg::dp_stat_t               stat,
  input  logic                            cfg_write,
  input  logic [psp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psp_pkg::CFG_W-1:0]       cfg_data,
  input  logic signed [11:0]              launch_x,
  input  logic signed [19:0]              launch_y,
  input  logic signed [15:0]              aim_angle,
  input  logic [11:0]                     launch_power,
  input  logic [9:0]                      elapsed_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      report_kind,
  output logic [3:0]                      slot_index,
  output logic                            accepted,
  output logic signed [15:0]              pos_x,
  output logic signed [15:0]              pos_y,
  output logic [4:0]                      removed_count,
  output logic                            last
);
  import psp_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MS = 16 - FRAC_BITS;
  localparam int VS = 24 - FRAC_BITS;
  localparam logic signed [30:0] MC_HALF = 31'sd1 <<< (MS - 1);
  localparam logic signed [42:0] V_HALF  = 43'sd1 <<< (VS - 1);

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  function automatic logic signed [24:0] ptrunc(input logic signed [23:0] v);
    logic signed [24:0] a;
    a = 25'(v);
    if (a < 0) begin
      return -((-a) >>> FRAC_BITS);
    end else begin
      return a >>> FRAC_BITS;
    end
  endfunction

  function automatic logic signed [15:0] pixel16(input logic signed [23:0] v);
    logic signed [24:0] p;
    p = ptrunc(v);
    if (p > 25'sd32767) begin
      return 16'sh7FFF;
    end else if (p < -25'sd32768) begin
      return 16'sh8000;
    end else begin
      return p[15:0];
    end
  endfunction

  // Configuration
  logic [9:0]  launch_speed, gravity;
  logic [7:0]  muzzle_offset;
  logic [11:0] field_width, field_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      launch_speed  <= RST_LAUNCH_SPEED;
      gravity       <= RST_GRAVITY;
      muzzle_offset <= RST_MUZZLE_OFFSET;
      field_width   <= RST_FIELD_WIDTH;
      field_height  <= RST_FIELD_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LAUNCH_SPEED:  launch_speed  <= cfg_data[9:0];
        REG_GRAVITY:       gravity       <= cfg_data[9:0];
        REG_MUZZLE_OFFSET: muzzle_offset <= cfg_data[7:0];
        REG_FIELD_WIDTH:   field_width   <= cfg_data;
        REG_FIELD_HEIGHT:  field_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latched item fields
  logic signed [11:0] r_lx;
  logic signed [19:0] r_ly;
  logic signed [15:0] r_angle;
  logic [11:0]        r_power;
  logic [9:0]         r_dt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_lx    <= launch_x;
      r_ly    <= launch_y;
      r_angle <= aim_angle;
      r_power <= launch_power;
      r_dt    <= elapsed_ms;
    end
  end

  // Slot walk index and live bits
  logic [CW-1:0]    idx;
  logic [IW-1:0]    ia;
  logic [SLOTS-1:0] live;
  logic             outside;

  assign ia = idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (cmd.sp_commit) begin
      live[ia] <= 1'b1;
    end else if (cmd.cl_check && outside) begin
      live[ia] <= 1'b0;
    end
  end

  // Angle and root unit
  logic               trig_busy;
  logic signed [20:0] cos_v, sin_v;
  logic [9:0]         root;

  psp_trig u_trig (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.trig_go),
    .angle (r_angle),
    .power (r_power),
    .busy  (trig_busy),
    .cos_v (cos_v),
    .sin_v (sin_v),
    .root  (root)
  );

  // Spawn products, two register stages
  logic [19:0]        rs;
  logic signed [29:0] mc, ms;
  logic signed [41:0] vcx, vcy;

  always_ff @(posedge clk) begin
    rs  <= root * launch_speed;
    mc  <= $signed({1'b0, muzzle_offset}) * cos_v;
    ms  <= $signed({1'b0, muzzle_offset}) * sin_v;
    vcx <= $signed({1'b0, rs}) * cos_v;
    vcy <= $signed({1'b0, rs}) * sin_v;
  end

  // Spawn results
  logic signed [23:0] lxf;
  logic signed [31:0] lys;
  logic signed [31:0] lyf;
  logic signed [30:0] mcr, msr;
  logic signed [42:0] vxr, vyr;
  logic signed [23:0] spx, spy, svx, svy;

  always_comb begin
    lxf = {{12{r_lx[11]}}, r_lx} <<< FRAC_BITS;
    lys = {{12{r_ly[19]}}, r_ly} <<< FRAC_BITS;
    lyf = lys >>> 8;
    mcr = (31'(mc) + MC_HALF) >>> MS;
    msr = (31'(ms) + MC_HALF) >>> MS;
    vxr = (43'(vcx) + V_HALF) >>> VS;
    vyr = (43'(vcy) + V_HALF) >>> VS;
    spx = sat24(48'(lxf) - 48'(mcr));
    spy = sat24(48'(lyf) - 48'(msr));
    svx = sat24(-48'(vxr));
    svy = sat24(-48'(vyr));
  end

  // Slot store: one row holds position and velocity
  logic [95:0]        mem [SLOTS];
  logic [95:0]        rd_row;
  logic signed [23:0] rpx, rpy, rvx, rvy;
  logic signed [23:0] npx, npy, nvy;

  assign rpx = rd_row[95:72];
  assign rpy = rd_row[71:48];
  assign rvx = rd_row[47:24];
  assign rvy = rd_row[23:0];

  always_ff @(posedge clk) begin
    if (cmd.sp_commit) begin
      mem[ia] <= {spx, spy, svx, svy};
    end else if (cmd.tk_commit) begin
      mem[ia] <= {npx, npy, rvx, nvy};
    end
    rd_row <= mem[ia];
  end

  // Tick: step products, then rounded division by 1000
  logic signed [34:0] mul_x, mul_y;
  logic [19:0]        gd;
  logic [35:0]        gdt;
  logic signed [35:0] dx_in;
  logic signed [25:0] qx, qy, dv;

  always_ff @(posedge clk) begin
    mul_x <= $signed({1'b0, r_dt}) * rvx;
    mul_y <= $signed({1'b0, r_dt}) * rvy;
  end

  assign gd    = gravity * r_dt;
  assign gdt   = {16'h0000, gd} << FRAC_BITS;
  assign dx_in = cmd.dv_sel ? $signed(gdt) : 36'(mul_x);

  psp_div1000 u_divx (
    .clk (clk),
    .num (dx_in),
    .quo (qx)
  );

  psp_div1000 u_divy (
    .clk (clk),
    .num (36'(mul_y)),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (cmd.dv_cap) begin
      dv <= qx;
    end
  end

  assign npx = sat24(48'(rpx) + 48'(qx));
  assign npy = sat24(48'(rpy) + 48'(qy));
  assign nvy = sat24(48'(rvy) + 48'(dv));

  // Report count for ticks, removal count for culls
  logic [4:0] rep_cnt;
  logic [4:0] rm_cnt;
  logic       rep_room;

  assign rep_room = !rep_cnt[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_cnt <= '0;
      rm_cnt  <= '0;
    end else if (cmd.load) begin
      rep_cnt <= '0;
      rm_cnt  <= '0;
    end else begin
      if (cmd.tk_commit && rep_room) begin
        rep_cnt <= rep_cnt + 5'd1;
      end
      if (cmd.cl_check && outside && rm_cnt != 5'd31) begin
        rm_cnt <= rm_cnt + 5'd1;
      end
    end
  end

  // Cull bounds on the truncated position
  logic signed [24:0] cx, cy;

  assign cx      = ptrunc(rpx);
  assign cy      = ptrunc(rpy);
  assign outside = (cx < 0) || (cx > $signed({13'h0000, field_width})) ||
                   (cy < 0) || (cy > $signed({13'h0000, field_height}));

  // Any live slot beyond the current one
  logic [SLOTS-1:0] above;
  logic             more_live;
  logic             last_pos;

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = live[j] && (CW'(j) > idx);
    end
  end

  assign more_live = |above;
  assign last_pos  = (rep_cnt == 5'd15) || !more_live;

  // Result register
  logic emit;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign emit     = cmd.sp_commit || cmd.emit_full || cmd.cl_emit ||
                    (cmd.tk_commit && rep_room);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sp_commit) begin
      report_kind   <= KIND_SPAWN;
      slot_index    <= 4'(idx);
      accepted      <= 1'b1;
      pos_x         <= pixel16(spx);
      pos_y         <= pixel16(spy);
      removed_count <= '0;
      last          <= 1'b1;
    end else if (cmd.emit_full) begin
      report_kind   <= KIND_SPAWN;
      slot_index    <= '0;
      accepted      <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      removed_count <= '0;
      last          <= 1'b1;
    end else if (cmd.tk_commit && rep_room) begin
      report_kind   <= KIND_POS;
      slot_index    <= 4'(idx);
      accepted      <= 1'b0;
      pos_x         <= pixel16(npx);
      pos_y         <= pixel16(npy);
      removed_count <= '0;
      last          <= last_pos;
    end else if (cmd.cl_emit) begin
      report_kind   <= KIND_CULL;
      slot_index    <= '0;
      accepted      <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      removed_count <= rm_cnt;
      last          <= 1'b1;
    end
  end

  // Status back to the controller
  assign stat.idx_end   = (idx == CW'(SLOTS));
  assign stat.live_here = live[ia];
  assign stat.trig_busy = trig_busy;
  assign stat.out_free  = out_free;
  assign stat.rep_room  = rep_room;

endmodule

FILE: hw/rtl/psp_ctrl.sv
// ----------------------------------------------------------------------------
// psp_ctrl
// Sequencer: accepts one item, walks the slots and steps the datapath
// through spawn, tick and cull.
// ----------------------------------------------------------------------------
module psp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  psp_pkg::dp_stat_t stat,
  output psp_pkg::dp_cmd_t  cmd
);
  import psp_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_SP_SCAN   = 17'h00002,
    S_SP_FULL   = 17'h00004,
    S_SP_TRIG   = 17'h00008,
    S_SP_PROD   = 17'h00010,
    S_SP_COMMIT = 17'h00020,
    S_TK_DV0    = 17'h00040,
    S_TK_DV1    = 17'h00080,
    S_TK_DV2    = 17'h00100,
    S_TK_SCAN   = 17'h00200,
    S_TK_W1     = 17'h00400,
    S_TK_W2     = 17'h00800,
    S_TK_W3     = 17'h01000,
    S_TK_UPD    = 17'h02000,
    S_CL_SCAN   = 17'h04000,
    S_CL_CHK    = 17'h08000,
    S_CL_EMIT   = 17'h10000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          case (command)
            CMD_SPAWN: state_next = S_SP_SCAN;
            CMD_TICK:  state_next = S_TK_DV0;
            CMD_CULL:  state_next = S_CL_SCAN;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      // Spawn: find the lowest free slot, run the angle and root unit
      S_SP_SCAN: begin
        if (stat.idx_end) begin
          state_next = S_SP_FULL;
        end else if (stat.live_here) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.trig_go = 1'b1;
          state_next  = S_SP_TRIG;
        end
      end
      S_SP_FULL: begin
        if (stat.out_free) begin
          cmd.emit_full = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SP_TRIG: begin
        if (!stat.trig_busy) begin
          state_next = S_SP_PROD;
        end
      end
      S_SP_PROD: begin
        state_next = S_SP_COMMIT;
      end
      S_SP_COMMIT: begin
        if (stat.out_free) begin
          cmd.sp_commit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      // Tick: gravity step first, then each live slot
      S_TK_DV0: begin
        cmd.dv_sel = 1'b1;
        state_next = S_TK_DV1;
      end
      S_TK_DV1: begin
        state_next = S_TK_DV2;
      end
      S_TK_DV2: begin
        cmd.dv_cap = 1'b1;
        state_next = S_TK_SCAN;
      end
      S_TK_SCAN: begin
        if (stat.idx_end) begin
          state_next = S_IDLE;
        end else if (stat.live_here) begin
          state_next = S_TK_W1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_TK_W1: begin
        state_next = S_TK_W2;
      end
      S_TK_W2: begin
        state_next = S_TK_W3;
      end
      S_TK_W3: begin
        state_next = S_TK_UPD;
      end
      S_TK_UPD: begin
        if (!stat.rep_room || stat.out_free) begin
          cmd.tk_commit = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_next    = S_TK_SCAN;
        end
      end
      // Cull: check each live slot, then report the count
      S_CL_SCAN: begin
        if (stat.idx_end) begin
          state_next = S_CL_EMIT;
        end else if (stat.live_here) begin
          state_next = S_CL_CHK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CL_CHK: begin
        cmd.cl_check = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_CL_SCAN;
      end
      S_CL_EMIT: begin
        if (stat.out_free) begin
          cmd.cl_emit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/projectile_slot_physics.sv
// ----------------------------------------------------------------------------
// projectile_slot_physics
// Table of projectile slots: spawn, Euler tick and cull, one item at a time.
// ----------------------------------------------------------------------------
// Spawn: a free-slot search, the 16 CORDIC/root steps and the product
//   registers; one result.
// Tick: the gravity step, then a scan of each slot and, per live slot, the
//   multiply, two divider stages and update; 0 to 16 results.
// Cull: a scan of each slot plus a check per live slot, then one result.
// Reset clears live bits, the sequencer and configuration to defaults.
// ----------------------------------------------------------------------------
module projectile_slot_physics #(
  parameter int SLOTS     = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [psp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic signed [11:0]            launch_x,
  input  logic signed [19:0]            launch_y,
  input  logic signed [15:0]            aim_angle,
  input  logic [11:0]                   launch_power,
  input  logic [9:0]                    elapsed_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    report_kind,
  output logic [3:0]                    slot_index,
  output logic                          accepted,
  output logic signed [15:0]            pos_x,
  output logic signed [15:0]            pos_y,
  output logic [4:0]                    removed_count,
  output logic                          last
);
  import psp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  psp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store and arithmetic
  psp_datapath #(
    .SLOTS     (SLOTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .launch_x      (launch_x),
    .launch_y      (launch_y),
    .aim_angle     (aim_angle),
    .launch_power  (launch_power),
    .elapsed_ms    (elapsed_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .report_kind   (report_kind),
    .slot_index    (slot_index),
    .accepted      (accepted),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .removed_count (removed_count),
    .last          (last)
  );

endmodule

FILE: bench/projectile_slot_physics_test.sv
// ----------------------------------------------------------------------------
// projectile_slot_physics_test
// Drives spawn, tick and cull items into the projectile slot table, predicts
// every report in a local bit-accurate copy of the table, and checks each
// report field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module projectile_slot_physics_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psp_pkg::*;

  localparam int NSLOTS     = 16;
  localparam int DRAIN_WAIT = 200;
  localparam int STUCK_MAX  = 20000;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [11:0] lx;
    logic signed [19:0] ly;
    logic signed [15:0] ang;
    logic [11:0]        pw;
    logic [9:0]         ms;
  } shot_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic        acc;
    logic [15:0] px;
    logic [15:0] py;
    logic [4:0]  rem;
    logic        fin;
  } report_t;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [1:0] command = '0;
  logic signed [11:0] launch_x = '0;
  logic signed [19:0] launch_y = '0;
  logic signed [15:0] aim_angle = '0;
  logic [11:0] launch_power = '0;
  logic [9:0] elapsed_ms = '0;
  logic out_valid, out_stall = 1;
  logic [1:0] report_kind;
  logic [3:0] slot_index;
  logic accepted;
  logic signed [15:0] pos_x, pos_y;
  logic [4:0] removed_count;
  logic last;

  projectile_slot_physics DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // model of the slot table
  longint speed_q, grav_q, muzzle_q, width_q, height_q;
  bit     live_q[NSLOTS];
  longint px_q[NSLOTS], py_q[NSLOTS], vx_q[NSLOTS], vy_q[NSLOTS];

  shot_t   pending_shots[$];
  report_t due_reports[$];
  int      send_gap_pct, recv_stall_pct;
  int      error_count = 0;
  int      stuck_cycles = 0;

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint div1000(longint n);
    longint t, q;
    t = n + 500;
    q = t / 1000;
    if (t % 1000 != 0 && t < 0) q--;
    return q;
  endfunction

  function automatic logic [15:0] to_pixel(longint v);
    longint p;
    p = v >= 0 ? (v >>> 8) : -((-v) >>> 8);
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function automatic longint trunc_pixel(longint v);
    return v >= 0 ? (v >>> 8) : -((-v) >>> 8);
  endfunction

  // rotate the gain vector by the angle; fold angles beyond a quarter turn
  task automatic rotate(input longint ang13, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = ang13 * 8; x = longint'(CORDIC_GAIN); y = 0; flip = 0;
    if (z > longint'(HALF_PI_Q16)) begin
      z -= longint'(PI_Q16); flip = 1;
    end else if (z < -longint'(HALF_PI_Q16)) begin
      z += longint'(PI_Q16); flip = 1;
    end
    for (int i = 0; i < TRIG_STEPS; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q16(i[3:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q16(i[3:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint floor_root(longint n);
    longint r;
    r = 0;
    for (int b = 10; b >= 0; b--)
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n) r += longint'(1) << b;
    return r;
  endfunction

  task automatic set_register(input cfg_reg_t idx, input int val);
    case (idx)
      REG_LAUNCH_SPEED:  speed_q  = val & 'h3FF;
      REG_GRAVITY:       grav_q   = val & 'h3FF;
      REG_MUZZLE_OFFSET: muzzle_q = val & 'hFF;
      REG_FIELD_WIDTH:   width_q  = val & 'hFFF;
      REG_FIELD_HEIGHT:  height_q = val & 'hFFF;
      default: ;
    endcase
  endtask

  // work out the reports of one accepted item and advance the table
  task automatic advance_table(input shot_t sh);
    report_t r;
    longint c, s, root, dt, dv, rem;
    int k, n;
    r = '{default: '0};
    case (sh.cmd)
      CMD_SPAWN: begin
        k = 0;
        while (k < NSLOTS && live_q[k]) k++;
        r.kind = KIND_SPAWN; r.fin = 1;
        if (k < NSLOTS) begin
          rotate(longint'(sh.ang), c, s);
          root = floor_root(longint'(sh.pw) << 8);
          px_q[k] = sat24(longint'(sh.lx) * 256 - round_sh(muzzle_q * c, 8));
          py_q[k] = sat24(longint'(sh.ly) - round_sh(muzzle_q * s, 8));
          vx_q[k] = sat24(-round_sh(root * speed_q * c, 16));
          vy_q[k] = sat24(-round_sh(root * speed_q * s, 16));
          live_q[k] = 1;
          r.slot = k[3:0]; r.acc = 1;
          r.px = to_pixel(px_q[k]); r.py = to_pixel(py_q[k]);
        end
        due_reports.push_back(r);
      end
      CMD_TICK: begin
        dt = longint'(sh.ms);
        dv = div1000(grav_q * dt * 256);
        n = 0;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!live_q[i]) continue;
          px_q[i] = sat24(px_q[i] + div1000(dt * vx_q[i]));
          py_q[i] = sat24(py_q[i] + div1000(dt * vy_q[i]));
          vy_q[i] = sat24(vy_q[i] + dv);
          r.kind = KIND_POS; r.slot = i[3:0];
          r.px = to_pixel(px_q[i]); r.py = to_pixel(py_q[i]);
          due_reports.push_back(r);
          n++;
        end
        if (n > 0) due_reports[$].fin = 1;
      end
      CMD_CULL: begin
        rem = 0;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!live_q[i]) continue;
          c = trunc_pixel(px_q[i]); s = trunc_pixel(py_q[i]);
          if (c < 0 || c > width_q || s < 0 || s > height_q) begin
            live_q[i] = 0; rem++;
          end
        end
        r.kind = KIND_CULL; r.rem = rem[4:0]; r.fin = 1;
        due_reports.push_back(r);
      end
      default: ;
    endcase
  endtask

  // drive items; load the next one only when the current one has gone
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) advance_table('{command, launch_x, launch_y,
                                                 aim_angle, launch_power, elapsed_ms});
      if (!in_valid || !in_stall) begin
        if (pending_shots.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          shot_t sh;
          sh = pending_shots.pop_front();
          command <= sh.cmd; launch_x <= sh.lx; launch_y <= sh.ly;
          aim_angle <= sh.ang; launch_power <= sh.pw; elapsed_ms <= sh.ms;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // check reports against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        $error("report with nothing expected: kind %0d slot %0d", report_kind, slot_index);
        error_count++;
      end else begin
        report_t e;
        e = due_reports.pop_front();
        if (report_kind !== e.kind) begin
          $error("report_kind expected %0d got %0d", e.kind, report_kind); error_count++;
        end
        if (slot_index !== e.slot) begin
          $error("slot_index expected %0d got %0d", e.slot, slot_index); error_count++;
        end
        if (accepted !== e.acc) begin
          $error("accepted expected %0d got %0d", e.acc, accepted); error_count++;
        end
        if (pos_x !== e.px) begin
          $error("pos_x expected %0d got %0d", $signed(e.px), pos_x); error_count++;
        end
        if (pos_y !== e.py) begin
          $error("pos_y expected %0d got %0d", $signed(e.py), pos_y); error_count++;
        end
        if (removed_count !== e.rem) begin
          $error("removed_count expected %0d got %0d", e.rem, removed_count); error_count++;
        end
        if (last !== e.fin) begin
          $error("last expected %0d got %0d", e.fin, last); error_count++;
        end
      end
    end
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic shot_t make_shot(logic [1:0] cmd, int lx, int ly, int ang, int pw, int ms);
    shot_t sh;
    sh.cmd = cmd; sh.lx = 12'(lx); sh.ly = 20'(ly); sh.ang = 16'(ang);
    sh.pw = 12'(pw); sh.ms = 10'(ms);
    return sh;
  endfunction

  function automatic shot_t random_shot();
    int pick;
    shot_t sh;
    pick = $urandom_range(99);
    sh.cmd = pick < 35 ? CMD_SPAWN : pick < 75 ? CMD_TICK : pick < 95 ? CMD_CULL : 2'd3;
    sh.lx  = 12'($urandom_range(3) == 0 ? $urandom() : $urandom_range(700));
    sh.ly  = 20'($urandom_range(3) == 0 ? $urandom() : $urandom_range(500 * 256));
    sh.ang = 16'($urandom_range(9) == 0 ? int'($urandom())
                                        : int'($urandom_range(51472)) - 25736);
    sh.pw  = 12'($urandom());
    sh.ms  = 10'($urandom_range(4) == 0 ? $urandom() : $urandom_range(60));
    return sh;
  endfunction

  task automatic wait_idle();
    while (pending_shots.size() > 0 || in_valid || due_reports.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_all(int sp, int gr, int mz, int fw, int fh);
    int vals[5];
    vals = '{sp, gr, mz, fw, fh};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_write <= 1; cfg_index <= cfg_reg_t'(i); cfg_data <= CFG_W'(vals[i]);
      set_register(cfg_reg_t'(i), vals[i]);
    end
    @(posedge clk);
    cfg_write <= 0;
  endtask

  initial begin
    speed_q = RST_LAUNCH_SPEED; grav_q = RST_GRAVITY; muzzle_q = RST_MUZZLE_OFFSET;
    width_q = RST_FIELD_WIDTH; height_q = RST_FIELD_HEIGHT;
    foreach (live_q[i]) begin
      live_q[i] = 0; px_q[i] = 0; py_q[i] = 0; vx_q[i] = 0; vy_q[i] = 0;
    end
    send_gap_pct = 6; recv_stall_pct = 69;
    repeat (11) @(posedge clk);
    rst <= 0;

    // empty table, ignored command, field extremes, then fill the table past full
    pending_shots.push_back(make_shot(CMD_TICK, 0, 0, 0, 0, 1023));
    pending_shots.push_back(make_shot(CMD_CULL, 0, 0, 0, 0, 0));
    pending_shots.push_back(make_shot(2'd3, -1, -1, -1, 4095, 1023));
    pending_shots.push_back(make_shot(CMD_SPAWN, -2048, -524288, -32768, 4095, 0));
    pending_shots.push_back(make_shot(CMD_SPAWN, 2047, 524287, 32767, 0, 0));
    pending_shots.push_back(make_shot(CMD_SPAWN, 320, 100 * 256, 25736, 256, 0));
    pending_shots.push_back(make_shot(CMD_SPAWN, 320, 100 * 256, -25736, 4095, 0));
    pending_shots.push_back(make_shot(CMD_SPAWN, 0, 0, 0, 1, 0));
    pending_shots.push_back(make_shot(CMD_TICK, 0, 0, 0, 0, 0));
    pending_shots.push_back(make_shot(CMD_TICK, 0, 0, 0, 0, 1023));
    for (int i = 0; i < 13; i++)
      pending_shots.push_back(make_shot(CMD_SPAWN, 300, 200 * 256, 12000, 1024, 0));
    pending_shots.push_back(make_shot(CMD_TICK, 0, 0, 0, 0, 500));
    pending_shots.push_back(make_shot(CMD_CULL, 0, 0, 0, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < 128; i++) pending_shots.push_back(random_shot());
      wait_idle();
      if (phase == 0) begin
        send_gap_pct = 69; recv_stall_pct = 6;
        write_all(1023, 0, 255, 4095, 4095);
      end else if (phase == 1) begin
        send_gap_pct = 0; recv_stall_pct = 0;
        write_all(1, 1023, 0, 0, 0);
      end
    end

    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
